>>> design/serial_port_register_model_core_defines.svh
// Assertion helpers for the serial port register core.
// Each check samples on clk and is disabled while rst_n is low.
`ifndef SERIAL_PORT_REGISTER_MODEL_CORE_DEFINES_SVH
`define SERIAL_PORT_REGISTER_MODEL_CORE_DEFINES_SVH

`ifndef SYNTH

// Check a property at every clock edge out of reset.
`define SPRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPRM_ASSERT(lbl, prop, msg)
`define SPRM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/sprm_pkg.sv
`default_nettype none

package sprm_pkg;

    // Register addresses, low 24 bits
    localparam logic [23:0] CTRL_ADDR = 24'h000000;
    localparam logic [23:0] TX_ADDR   = 24'h000004;
    localparam logic [23:0] RX_ADDR   = 24'h000008;

    localparam logic [3:0] IRQ_LEVEL = 4'd12;

    // Only the top byte lane carries the data byte
    localparam logic [3:0] TOP_LANE_MASK = 4'b1000;

    // Lane of the transmit byte on a read: low address bits 0 pick bits 31:24
    localparam int TX_LANE_SHIFT = 24 - 8 * (TX_ADDR % 4);

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_TXRDY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_BUSY = 2'd2
    } mode_t;

endpackage

`default_nettype wire

>>> design/serial_port_register_model_core.sv
`default_nettype none

// Byte serial port with control, transmit and receive registers. Each input
// word is one event: a bus read, a bus write, a receive byte offered by the
// line, or a transmit-line-ready event; each event yields exactly one result
// word carrying read data, receive acceptance, an optional transmit byte and
// the interrupt level after the event. Both channels use valid/stall. The
// core takes one event per clock unless the result side stalls: an event
// sits in the input register while the register state is updated, then its
// result sits in the result register. The single update path from input
// register to state and result register sets that throughput; a stalled
// result holds the input register, which in turn stalls the input side.
// Control read returns {rx_full, tx_full, rx_irq_en, rx_en, tx_en} in bits
// 4:0. Receive register reads return data only when lane_enable selects just
// the top lane, but always acknowledge a pending receive byte.

`include "serial_port_register_model_core_defines.svh"

module serial_port_register_model_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [23:0] addr,
    input  wire logic [3:0]  lane_enable,
    input  wire logic [31:0] write_data,
    input  wire logic [7:0]  rx_byte,

    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [31:0] read_data,
    output      logic        rx_taken,
    output      logic        tx_valid,
    output      logic [7:0]  tx_byte,
    output      logic [3:0]  irq_level
);

    import sprm_pkg::*;

    // ---------------------------------------------------------------
    // Handshake control
    // ---------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic in_accept;

    // Advance the held event whenever the result register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // Input register (payload, no reset)
    // ---------------------------------------------------------------
    func_t       func_reg;
    logic [23:0] addr_reg;
    logic [3:0]  lane_enable_reg;
    logic [31:0] write_data_reg;
    logic [7:0]  rx_byte_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg        <= func_t'(func);
            addr_reg        <= addr;
            lane_enable_reg <= lane_enable;
            write_data_reg  <= write_data;
            rx_byte_reg     <= rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Port state
    // ---------------------------------------------------------------
    mode_t       tx_mode_reg,    tx_mode_next;
    mode_t       rx_mode_reg,    rx_mode_next;
    logic        tx_en_reg,      tx_en_next;
    logic        rx_en_reg,      rx_en_next;
    logic        rx_irq_en_reg,  rx_irq_en_next;
    logic        tx_full_reg,    tx_full_next;
    logic        rx_full_reg,    rx_full_next;
    logic [7:0]  tx_hold_reg,    tx_hold_next;
    logic [7:0]  rx_hold_reg,    rx_hold_next;
    logic [3:0]  irq_reg,        irq_next;

    logic        hit_ctrl;
    logic        hit_tx;
    logic        hit_rx;
    logic [2:0]  ctrl_bits;

    // Address decode, priority control > transmit > receive
    assign hit_ctrl = (addr_reg == CTRL_ADDR);
    assign hit_tx   = !hit_ctrl && (addr_reg == TX_ADDR);
    assign hit_rx   = !hit_ctrl && !hit_tx && (addr_reg == RX_ADDR);

    // Only lane 0 of a control write reaches the enable bits
    assign ctrl_bits = write_data_reg[2:0] & {3{lane_enable_reg[0]}};

    // Next state of both state machines and the holding registers
    always_comb
    begin
        tx_mode_next   = tx_mode_reg;
        rx_mode_next   = rx_mode_reg;
        tx_en_next     = tx_en_reg;
        rx_en_next     = rx_en_reg;
        rx_irq_en_next = rx_irq_en_reg;
        tx_full_next   = tx_full_reg;
        rx_full_next   = rx_full_reg;
        tx_hold_next   = tx_hold_reg;
        rx_hold_next   = rx_hold_reg;
        irq_next       = irq_reg;

        case (func_reg)
            FUNC_WRITE:
            begin
                if (hit_ctrl)
                begin
                    tx_en_next     = ctrl_bits[0];
                    rx_en_next     = ctrl_bits[1];
                    rx_irq_en_next = ctrl_bits[2];

                    if (tx_mode_reg == MODE_OFF && ctrl_bits[0])
                        tx_mode_next = MODE_ON;
                    else if (tx_mode_reg == MODE_ON && !ctrl_bits[0])
                    begin
                        tx_mode_next = MODE_OFF;
                        tx_full_next = 1'b0;
                    end

                    if (rx_mode_reg == MODE_OFF && ctrl_bits[1])
                    begin
                        rx_mode_next = MODE_ON;
                        rx_full_next = 1'b0;
                    end
                    else if (rx_mode_reg == MODE_BUSY && !ctrl_bits[1])
                    begin
                        rx_mode_next = MODE_OFF;
                        rx_full_next = 1'b0;
                        rx_hold_next = '0;
                        irq_next     = '0;
                    end
                end
                else if (hit_tx && tx_mode_reg == MODE_ON)
                begin
                    // A partial-lane write still starts the transmitter
                    if (lane_enable_reg == TOP_LANE_MASK)
                        tx_hold_next = write_data_reg[31:24];
                    tx_full_next = 1'b1;
                    tx_mode_next = MODE_BUSY;
                end
            end
            FUNC_READ:
            begin
                // Reading the receive register acknowledges the byte
                if (hit_rx && rx_mode_reg == MODE_BUSY)
                begin
                    rx_mode_next = MODE_ON;
                    rx_full_next = 1'b0;
                    irq_next     = '0;
                end
            end
            FUNC_RX:
            begin
                if (rx_mode_reg == MODE_ON)
                begin
                    rx_mode_next = MODE_BUSY;
                    rx_full_next = 1'b1;
                    rx_hold_next = rx_byte_reg;
                    if (rx_irq_en_reg)
                        irq_next = IRQ_LEVEL;
                end
            end
            FUNC_TXRDY:
            begin
                if (tx_mode_reg == MODE_BUSY)
                begin
                    tx_full_next = 1'b0;
                    tx_mode_next = MODE_ON;
                end
            end
            default:
            begin
                tx_mode_next = tx_mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_mode_reg   <= MODE_OFF;
            rx_mode_reg   <= MODE_OFF;
            tx_en_reg     <= 1'b0;
            rx_en_reg     <= 1'b0;
            rx_irq_en_reg <= 1'b0;
            tx_full_reg   <= 1'b0;
            rx_full_reg   <= 1'b0;
            tx_hold_reg   <= '0;
            rx_hold_reg   <= '0;
            irq_reg       <= '0;
        end
        else if (advance)
        begin
            tx_mode_reg   <= tx_mode_next;
            rx_mode_reg   <= rx_mode_next;
            tx_en_reg     <= tx_en_next;
            rx_en_reg     <= rx_en_next;
            rx_irq_en_reg <= rx_irq_en_next;
            tx_full_reg   <= tx_full_next;
            rx_full_reg   <= rx_full_next;
            tx_hold_reg   <= tx_hold_next;
            rx_hold_reg   <= rx_hold_next;
            irq_reg       <= irq_next;
        end
    end

    // ---------------------------------------------------------------
    // Result word for the event in the input register
    // ---------------------------------------------------------------
    logic [31:0] read_data_next;
    logic        rx_taken_next;
    logic        tx_valid_next;
    logic [7:0]  tx_byte_next;

    always_comb
    begin
        read_data_next = '0;
        rx_taken_next  = 1'b0;
        tx_valid_next  = 1'b0;
        tx_byte_next   = '0;

        case (func_reg)
            FUNC_READ:
            begin
                if (hit_ctrl)
                    read_data_next = {27'd0, rx_full_reg, tx_full_reg, rx_irq_en_reg,
                                      rx_en_reg, tx_en_reg};
                else if (hit_tx)
                    read_data_next = 32'(tx_hold_reg) << TX_LANE_SHIFT;
                else if (hit_rx && lane_enable_reg == TOP_LANE_MASK)
                    read_data_next = {rx_hold_reg, 24'd0};
            end
            FUNC_RX:
            begin
                rx_taken_next = (rx_mode_reg == MODE_ON);
            end
            FUNC_TXRDY:
            begin
                if (tx_mode_reg == MODE_BUSY)
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = tx_hold_reg;
                end
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
    end

    // Result register (payload, no reset); hold while stalled
    logic [31:0] read_data_reg;
    logic        rx_taken_reg;
    logic        tx_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic [3:0]  irq_level_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= read_data_next;
            rx_taken_reg  <= rx_taken_next;
            tx_valid_reg  <= tx_valid_next;
            tx_byte_reg   <= tx_byte_next;
            irq_level_reg <= irq_next;
        end
    end

    assign read_data = read_data_reg;
    assign rx_taken  = rx_taken_reg;
    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign irq_level = irq_level_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SPRM_ASSERT(a_rx_full_tracks_mode, rx_full_reg == (rx_mode_reg == MODE_BUSY), "rx full flag out of step with receive mode")
    `SPRM_ASSERT(a_tx_full_tracks_mode, tx_full_reg == (tx_mode_reg == MODE_BUSY), "tx full flag out of step with transmit mode")
    `SPRM_ASSERT(a_irq_needs_rx_data, (irq_reg == 4'd0) || (rx_mode_reg == MODE_BUSY), "interrupt raised without pending receive byte")
    `SPRM_ASSERT_NEXT(a_tx_drain_sends, advance && func_reg == FUNC_TXRDY && tx_mode_reg == MODE_BUSY, out_valid && tx_valid, "line ready with full transmitter sent nothing")

endmodule

`default_nettype wire
